[sv/amcd_pkg.sv]
package amcd_pkg;

  localparam int STORE_DEPTH_DEF = 26;
  localparam int CNT_W           = 5;
  localparam int FIELD_COUNT     = 5;
  localparam int FIELD_IDX_W     = $clog2(FIELD_COUNT);
  localparam int NUM_W           = 12;
  localparam int DIGIT_W         = 9;

  localparam logic [7:0] NEWLINE_CODE    = 8'd10;
  localparam logic [7:0] ASCII_ZERO      = 8'd48;
  localparam logic [7:0] SERVO_UP_CHAR   = 8'd49;
  localparam logic [7:0] SERVO_DOWN_CHAR = 8'd50;

  localparam logic [11:0] SERVO_UP_PULSE   = 12'd3900;
  localparam logic [11:0] SERVO_DOWN_PULSE = 12'd2500;

  localparam logic signed [NUM_W-1:0] BRAKE_NUM   = 12'sd5;
  localparam logic signed [NUM_W-1:0] FWD_MIN_NUM = 12'sd6;
  localparam logic signed [NUM_W-1:0] FWD_MAX_NUM = 12'sd10;
  localparam logic signed [NUM_W-1:0] REV_MIN_NUM = 12'sd0;

  typedef struct packed {
    logic [7:0] duty;
    logic       in1;
    logic       in2;
  } motor_state_t;

  localparam motor_state_t MOTOR_RESET = '{duty: 8'd0, in1: 1'b1, in2: 1'b1};

  // duty for forward numbers six through ten
  function automatic logic [7:0] fwd_duty(input logic [2:0] idx);
    logic [7:0] d;
    unique case (idx)
      3'd0:    d = 8'd50;
      3'd1:    d = 8'd100;
      3'd2:    d = 8'd150;
      3'd3:    d = 8'd200;
      3'd4:    d = 8'd255;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

  // duty for reverse numbers zero through four
  function automatic logic [7:0] rev_duty(input logic [2:0] idx);
    logic [7:0] d;
    unique case (idx)
      3'd0:    d = 8'd255;
      3'd1:    d = 8'd200;
      3'd2:    d = 8'd150;
      3'd3:    d = 8'd100;
      3'd4:    d = 8'd50;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

  // signed character minus ascii zero
  function automatic logic signed [DIGIT_W-1:0] digit_of(input logic [7:0] b);
    logic signed [DIGIT_W-1:0] s;
    s = $signed({b[7], b});
    return s - $signed({1'b0, ASCII_ZERO});
  endfunction

  // tens * 10 + units, exact in 12 bits
  function automatic logic signed [NUM_W-1:0] motor_number(input logic [7:0] tens,
                                                           input logic [7:0] units);
    logic signed [DIGIT_W-1:0] dt;
    logic signed [DIGIT_W-1:0] du;
    logic signed [NUM_W-1:0]   t;
    logic signed [NUM_W-1:0]   u;
    dt = digit_of(tens);
    du = digit_of(units);
    t  = $signed({{(NUM_W-DIGIT_W){dt[DIGIT_W-1]}}, dt});
    u  = $signed({{(NUM_W-DIGIT_W){du[DIGIT_W-1]}}, du});
    return (t <<< 3) + (t <<< 1) + u;
  endfunction

endpackage

[sv/amcd_motor_drive.sv]
module amcd_motor_drive (
  input  logic signed [amcd_pkg::NUM_W-1:0] num,
  input  amcd_pkg::motor_state_t            cur,
  output amcd_pkg::motor_state_t            nxt
);
  import amcd_pkg::*;

  logic signed [NUM_W-1:0] fwd_off;

  assign fwd_off = num - FWD_MIN_NUM;

  always_comb begin
    nxt = cur;
    priority if (num > BRAKE_NUM) begin
      nxt.in1 = 1'b1;
      nxt.in2 = 1'b0;
      if (num <= FWD_MAX_NUM) begin
        nxt.duty = fwd_duty(fwd_off[2:0]);
      end
    end else if (num < BRAKE_NUM) begin
      nxt.in1 = 1'b0;
      nxt.in2 = 1'b1;
      if (num >= REV_MIN_NUM) begin
        nxt.duty = rev_duty(num[2:0]);
      end
    end else begin
      // exactly five: brake
      nxt = MOTOR_RESET;
    end
  end

endmodule

[sv/ascii_motor_command_decoder_top.sv]
// ascii motor command decoder
// input channel: one received serial byte per transaction on in_rx_byte,
//   qualified by in_valid, held off by in_stall
// result channel: one transaction per input byte, showing both motors'
//   duty and bridge pins, the servo pulse and whether this byte (a newline
//   in sixth place) completed a packet
// order: an accepted byte is captured in the input register and its result
//   then in the result register, which raises out_valid
// throughput: one byte per cycle while out_stall does not hold a result; the
//   limit is the update of the byte counter and motor state, done between the
//   input register and the result register
// stall: when out_stall holds a result, the byte in the input register
//   waits and in_stall rises only if that register is occupied too
// reset: rst_n low at a clock edge empties both stages, clears the byte
//   count, brakes both motors with duty 0 and zeroes the servo pulse
module ascii_motor_command_decoder_top #(
  parameter int STORE_DEPTH = amcd_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_motor_a_duty,
  output logic        out_motor_a_in1,
  output logic        out_motor_a_in2,
  output logic [7:0]  out_motor_b_duty,
  output logic        out_motor_b_in1,
  output logic        out_motor_b_in2,
  output logic [11:0] out_servo_pulse,
  output logic        out_packet_decoded
);
  import amcd_pkg::*;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // result stage and block state; the state registers are the result
  logic             out_valid_r;
  logic             decoded_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [7:0]       field_r [FIELD_COUNT];
  motor_state_t     motor_a_r;
  motor_state_t     motor_b_r;
  motor_state_t     motor_a_nxt;
  motor_state_t     motor_b_nxt;
  logic [11:0]      servo_r;
  logic             last_two_r;   // last accepted servo choice was two

  logic advance;
  logic in_take;
  logic in_range;
  logic is_newline;
  logic store_we;
  logic do_decode;
  logic servo_up;
  logic servo_down;

  logic signed [NUM_W-1:0] num_a;
  logic signed [NUM_W-1:0] num_b;

  // move the input byte on whenever the result slot is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // packet framing
  assign in_range   = count_r < CNT_W'(STORE_DEPTH);
  assign is_newline = s1_byte_r == NEWLINE_CODE;
  assign store_we   = advance && in_range && (count_r < CNT_W'(FIELD_COUNT));
  // newline in sixth place completes a packet
  assign do_decode  = advance && in_range && is_newline && (count_r == CNT_W'(FIELD_COUNT));

  always_comb begin
    // full store drops the byte and restarts; any stored newline restarts
    if (!in_range || is_newline) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

  // packet bytes; only read after all five have been written
  always_ff @(posedge clk) begin
    if (store_we) begin
      field_r[count_r[FIELD_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // decode
  assign num_a = motor_number(field_r[0], field_r[1]);
  assign num_b = motor_number(field_r[2], field_r[3]);

  amcd_motor_drive u_drive_a (
    .num (num_a),
    .cur (motor_a_r),
    .nxt (motor_a_nxt)
  );

  amcd_motor_drive u_drive_b (
    .num (num_b),
    .cur (motor_b_r),
    .nxt (motor_b_nxt)
  );

  // servo only moves on a change of choice
  assign servo_up   = (field_r[4] == SERVO_UP_CHAR) && last_two_r;
  assign servo_down = (field_r[4] == SERVO_DOWN_CHAR) && !last_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_a_r  <= MOTOR_RESET;
      motor_b_r  <= MOTOR_RESET;
      servo_r    <= '0;
      last_two_r <= 1'b0;
    end else if (do_decode) begin
      motor_a_r <= motor_a_nxt;
      motor_b_r <= motor_b_nxt;
      priority if (servo_up) begin
        servo_r    <= SERVO_UP_PULSE;
        last_two_r <= 1'b0;
      end else if (servo_down) begin
        servo_r    <= SERVO_DOWN_PULSE;
        last_two_r <= 1'b1;
      end else begin
        servo_r    <= servo_r;
        last_two_r <= last_two_r;
      end
    end
  end

  // result valid and decode flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      decoded_r   <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      decoded_r   <= do_decode;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_a_duty   = motor_a_r.duty;
  assign out_motor_a_in1    = motor_a_r.in1;
  assign out_motor_a_in2    = motor_a_r.in2;
  assign out_motor_b_duty   = motor_b_r.duty;
  assign out_motor_b_in1    = motor_b_r.in1;
  assign out_motor_b_in2    = motor_b_r.in2;
  assign out_servo_pulse    = servo_r;
  assign out_packet_decoded = decoded_r;

endmodule

[sv/amcd_checker.sv]
module amcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_motor_a_duty,
  input logic        out_motor_a_in1,
  input logic        out_motor_a_in2,
  input logic [7:0]  out_motor_b_duty,
  input logic        out_motor_b_in1,
  input logic        out_motor_b_in2,
  input logic [11:0] out_servo_pulse,
  input logic        out_packet_decoded
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_a_duty)
      && $stable(out_motor_b_duty) && $stable(out_servo_pulse)
      && $stable(out_packet_decoded))
    else $error("stalled result changed");

  // a bridge is never left with both inputs low
  a_pins_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_motor_a_in1 || out_motor_a_in2)
      && (out_motor_b_in1 || out_motor_b_in2))
    else $error("motor bridge floating");

  // braking always comes with zero duty
  a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_motor_a_in1 && out_motor_a_in2) || out_motor_a_duty == 8'd0)
      && (!(out_motor_b_in1 && out_motor_b_in2) || out_motor_b_duty == 8'd0))
    else $error("brake with nonzero duty");

  // servo pulse only takes its idle or two commanded positions
  a_servo_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_servo_pulse == 12'd0 || out_servo_pulse == 12'd2500
      || out_servo_pulse == 12'd3900)
    else $error("servo pulse out of set");

endmodule

bind ascii_motor_command_decoder_top amcd_checker u_amcd_checker (.*);

[sim/motor_command_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the ascii motor command decoder, predicts each
// result transaction from the accepted bytes and compares it field by field
module motor_command_checker #(
  parameter int STORE_DEPTH = amcd_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_motor_a_duty,
  input  logic        out_motor_a_in1,
  input  logic        out_motor_a_in2,
  input  logic [7:0]  out_motor_b_duty,
  input  logic        out_motor_b_in1,
  input  logic        out_motor_b_in2,
  input  logic [11:0] out_servo_pulse,
  input  logic        out_packet_decoded,
  output int          mismatches,
  output int          awaited
);

  typedef struct packed {
    amcd_pkg::motor_state_t motor_a;
    amcd_pkg::motor_state_t motor_b;
    logic [11:0]            servo;
    logic                   decoded;
  } panel_t;

  // predicted decoder state
  int                     fill;
  logic [7:0]             held [5];
  amcd_pkg::motor_state_t motor_a;
  amcd_pkg::motor_state_t motor_b;
  logic [11:0]            servo;
  logic [7:0]             last_servo_char;

  panel_t expected_panel [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic int char_value(input logic [7:0] b);
    return int'($signed(b)) - int'(amcd_pkg::ASCII_ZERO);
  endfunction

  // duty tables: forward runs up from six, reverse runs down from zero
  function automatic logic [7:0] table_duty(input int idx);
    logic [7:0] d;
    case (idx)
      0:       d = 8'd50;
      1:       d = 8'd100;
      2:       d = 8'd150;
      3:       d = 8'd200;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

  task automatic steer(input int num, inout amcd_pkg::motor_state_t m);
    if (num > 5) begin
      m.in1 = 1'b1;
      m.in2 = 1'b0;
      if (num <= 10) m.duty = table_duty(num - 6);
    end else if (num < 5) begin
      m.in1 = 1'b0;
      m.in2 = 1'b1;
      if (num >= 0) m.duty = table_duty(4 - num);
    end else begin
      m = '{duty: 8'd0, in1: 1'b1, in2: 1'b1};
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, output panel_t res);
    res.decoded = 1'b0;
    if (fill < STORE_DEPTH) begin
      if (fill < 5) held[fill] = b;
      fill++;
      if (b == amcd_pkg::NEWLINE_CODE) begin
        if (fill == 6) begin
          steer(char_value(held[0]) * 10 + char_value(held[1]), motor_a);
          steer(char_value(held[2]) * 10 + char_value(held[3]), motor_b);
          // servo moves only on a change of choice
          if (held[4] != last_servo_char) begin
            if (held[4] == amcd_pkg::SERVO_UP_CHAR) begin
              servo           = amcd_pkg::SERVO_UP_PULSE;
              last_servo_char = amcd_pkg::SERVO_UP_CHAR;
            end else if (held[4] == amcd_pkg::SERVO_DOWN_CHAR) begin
              servo           = amcd_pkg::SERVO_DOWN_PULSE;
              last_servo_char = amcd_pkg::SERVO_DOWN_CHAR;
            end
          end
          res.decoded = 1'b1;
        end
        fill = 0;
      end
    end else begin
      // store full: byte dropped
      fill = 0;
    end
    res.motor_a = motor_a;
    res.motor_b = motor_b;
    res.servo   = servo;
  endtask

  always @(posedge clk) begin : watch
    panel_t want;
    panel_t next_want;
    if (!rst_n) begin
      fill            = 0;
      motor_a         = amcd_pkg::MOTOR_RESET;
      motor_b         = amcd_pkg::MOTOR_RESET;
      servo           = 12'd0;
      last_servo_char = amcd_pkg::SERVO_UP_CHAR;
      expected_panel.delete();
      mismatches      = 0;
      awaited         = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_panel.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_panel.pop_front();
          check_field("motor_a_duty", out_motor_a_duty, want.motor_a.duty);
          check_field("motor_a_in1", out_motor_a_in1, want.motor_a.in1);
          check_field("motor_a_in2", out_motor_a_in2, want.motor_a.in2);
          check_field("motor_b_duty", out_motor_b_duty, want.motor_b.duty);
          check_field("motor_b_in1", out_motor_b_in1, want.motor_b.in1);
          check_field("motor_b_in2", out_motor_b_in2, want.motor_b.in2);
          check_field("servo_pulse", out_servo_pulse, want.servo);
          check_field("packet_decoded", out_packet_decoded, want.decoded);
        end
      end
      if (in_valid && !in_stall) begin
        absorb_byte(in_rx_byte, next_want);
        expected_panel.push_back(next_want);
      end
      awaited = expected_panel.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int STORE_DEPTH = amcd_pkg::STORE_DEPTH_DEF;
  // random part stops once this many bytes have gone in
  localparam int BYTE_TARGET = 1300;
  // the last stretch of the run has no idling on either side
  localparam int CALM_TAIL   = 150;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_motor_a_duty;
  logic        out_motor_a_in1;
  logic        out_motor_a_in2;
  logic [7:0]  out_motor_b_duty;
  logic        out_motor_b_in1;
  logic        out_motor_b_in2;
  logic [11:0] out_servo_pulse;
  logic        out_packet_decoded;

  int mismatches;
  int awaited;
  int bytes_sent;
  bit calm;

  ascii_motor_command_decoder_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_a_duty   (out_motor_a_duty),
    .out_motor_a_in1    (out_motor_a_in1),
    .out_motor_a_in2    (out_motor_a_in2),
    .out_motor_b_duty   (out_motor_b_duty),
    .out_motor_b_in1    (out_motor_b_in1),
    .out_motor_b_in2    (out_motor_b_in2),
    .out_servo_pulse    (out_servo_pulse),
    .out_packet_decoded (out_packet_decoded)
  );

  // prediction and comparison live in the checker; the top only drives
  motor_command_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_a_duty   (out_motor_a_duty),
    .out_motor_a_in1    (out_motor_a_in1),
    .out_motor_a_in2    (out_motor_a_in2),
    .out_motor_b_duty   (out_motor_b_duty),
    .out_motor_b_in1    (out_motor_b_in1),
    .out_motor_b_in2    (out_motor_b_in2),
    .out_servo_pulse    (out_servo_pulse),
    .out_packet_decoded (out_packet_decoded),
    .mismatches         (mismatches),
    .awaited            (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ascii code of a decimal digit
  function automatic logic [7:0] dig(input int n);
    return amcd_pkg::ASCII_ZERO + 8'(n);
  endfunction

  // any byte except a newline, so it cannot end a packet early
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == amcd_pkg::NEWLINE_CODE);
    return b;
  endfunction

  // tens digit: mostly 0 or 1 so the motor number lands in the duty table
  function automatic logic [7:0] pick_tens();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return dig($urandom_range(0, 1));
    else if (r < 17) return dig($urandom_range(0, 9));
    else return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_units();
    if ($urandom_range(0, 4) != 0) return dig($urandom_range(0, 9));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_servo();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return amcd_pkg::SERVO_UP_CHAR;
    else if (r < 8) return amcd_pkg::SERVO_DOWN_CHAR;
    else return 8'($urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, or later after an idle burst
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
    // random idle burst on the sender side
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic send_packet(input logic [7:0] a_tens, input logic [7:0] a_units,
                             input logic [7:0] b_tens, input logic [7:0] b_units,
                             input logic [7:0] servo_char);
    send_byte(a_tens);
    send_byte(a_units);
    send_byte(b_tens);
    send_byte(b_units);
    send_byte(servo_char);
    send_byte(amcd_pkg::NEWLINE_CODE);
  endtask

  // receiver stall bursts, none in the calm tail
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int kind;
    int len;
    in_valid   = 1'b0;
    in_rx_byte = 8'd0;
    rst_n      = 1'b0;
    bytes_sent = 0;
    calm       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    // motor a at fifty-five goes forward with duty kept, motor b at ten is full forward, servo down
    send_packet(dig(5), dig(5), dig(1), dig(0), amcd_pkg::SERVO_DOWN_CHAR);
    // all-ones and all-zero bytes give a negative number: reverse pins,
    // duty kept; motor b at six is lowest forward; servo back up
    send_packet(8'hFF, 8'h00, dig(0), dig(6), amcd_pkg::SERVO_UP_CHAR);
    // zero and four are the ends of the reverse table; same servo choice again
    send_packet(dig(0), dig(0), dig(0), dig(4), amcd_pkg::SERVO_UP_CHAR);
    // numbers far past ten and far below zero, servo digit with no effect
    send_packet(8'h7F, dig(9), 8'h80, 8'hFE, dig(7));
    // a lone newline is a short packet
    send_byte(amcd_pkg::NEWLINE_CODE);

    // random part
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= BYTE_TARGET - CALM_TAIL) calm = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // well-formed packet with random content
        send_packet(pick_tens(), pick_units(), pick_tens(), pick_units(), pick_servo());
      end else if (kind < 70) begin
        // short packet
        len = $urandom_range(0, 4);
        repeat (len) send_byte(plain_byte());
        send_byte(amcd_pkg::NEWLINE_CODE);
      end else if (kind < 80) begin
        // long packet, still inside the store
        len = $urandom_range(6, STORE_DEPTH - 1);
        repeat (len) send_byte(plain_byte());
        send_byte(amcd_pkg::NEWLINE_CODE);
      end else if (kind < 86) begin
        // fill the store to the brim, then the next byte is dropped
        len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 4);
        repeat (len) send_byte(plain_byte());
        if ($urandom_range(0, 1) == 1) send_byte(amcd_pkg::NEWLINE_CODE);
        send_packet(pick_tens(), pick_units(), pick_tens(), pick_units(), pick_servo());
      end else begin
        // raw noise, newlines allowed
        len = $urandom_range(1, 8);
        repeat (len) send_byte(8'($urandom));
      end
    end

    in_valid <= 1'b0;
    wait (awaited == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
